// ===== hw/rtl/b1553_pkg.sv =====
// Package for the 1553 word transmitter: request opcode and sequencer state types and the
// half-bit position constants of the lead-in and word frame. No dependencies.
package b1553_pkg;

    // Request opcodes
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_LOAD  = 2'd1,
        OP_ABORT = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    // Sequencer state
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_LEAD = 2'd1,
        ST_WORD = 2'd2
    } send_state_t;

    localparam int PHASE_W = 6;
    localparam int WORD_W  = 16;

    // Half-bit positions: lead-in 0..1, word 0..39
    localparam logic [PHASE_W-1:0] LEAD_LAST    = 6'd1;
    localparam logic [PHASE_W-1:0] SYNC_SWAP    = 6'd3;
    localparam logic [PHASE_W-1:0] SYNC_END     = 6'd6;
    localparam logic [PHASE_W-1:0] PARITY_START = 6'd38;
    localparam logic [PHASE_W-1:0] WORD_LAST    = 6'd39;

endpackage

// ===== hw/rtl/bus_1553_word_transmitter_top.sv =====
// Top level of the 1553 Manchester II word transmitter: sequencer state,
// request decode and result register. Depends on b1553_pkg.
//
// The block takes one request (tick, load, abort or none) per clock and gives one
// result per request, in the cycle after acceptance, from a single result
// register. A tick drives the levels of the current half-bit, then advances
// one half-bit; load, abort and none report the levels the next tick will drive.
// All decoding is done in one pass between the sequencer registers and the
// result register, so requests flow back to back; the input stalls only
// while a result waits under a stalled output.
module bus_1553_word_transmitter_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [15:0] data_word,
    input  logic        sync_kind,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        pos_drive,
    output logic        neg_drive,
    output logic        busy_res,
    output logic        word_end
);

    b1553_pkg::send_state_t             sending_reg, sending_next;
    logic [b1553_pkg::PHASE_W-1:0]      phase_reg, phase_next;
    logic [b1553_pkg::WORD_W-1:0]       shift_reg, shift_next;
    logic                               parity_reg, parity_next;
    logic                               kind_reg, kind_next;
    logic [b1553_pkg::WORD_W-1:0]       pend_word_reg, pend_word_next;
    logic                               pend_kind_reg, pend_kind_next;
    logic                               pend_valid_reg, pend_valid_next;

    logic out_valid_reg, out_valid_next;
    logic pos_reg, pos_next;
    logic neg_reg, neg_next;
    logic busy_reg, busy_next;
    logic end_reg, end_next;

    logic in_accept;
    logic out_accept;
    logic word_done;

    // Levels seen by the result: current state on tick, updated state otherwise
    b1553_pkg::send_state_t             view_state;
    logic [b1553_pkg::PHASE_W-1:0]      view_phase;
    logic                               view_msb;
    logic                               view_parity;
    logic                               view_kind;
    logic                               level;

    assign out_accept = out_valid_reg && !out_stall;
    assign in_stall   = out_valid_reg && out_stall;
    assign in_accept  = in_valid && !in_stall;

    // Next sequencer state
    always_comb
    begin
        sending_next    = sending_reg;
        phase_next      = phase_reg;
        shift_next      = shift_reg;
        parity_next     = parity_reg;
        kind_next       = kind_reg;
        pend_word_next  = pend_word_reg;
        pend_kind_next  = pend_kind_reg;
        pend_valid_next = pend_valid_reg;
        word_done       = 1'b0;
        if (in_accept)
        begin
            case (b1553_pkg::opcode_t'(opcode))
                b1553_pkg::OP_TICK:
                begin
                    if (sending_reg == b1553_pkg::ST_LEAD)
                    begin
                        if (phase_reg >= b1553_pkg::LEAD_LAST)
                        begin
                            sending_next = b1553_pkg::ST_WORD;
                            phase_next   = '0;
                            parity_next  = 1'b0;
                        end
                        else
                        begin
                            phase_next = phase_reg + 1'b1;
                        end
                    end
                    else if (sending_reg == b1553_pkg::ST_WORD)
                    begin
                        if (phase_reg >= b1553_pkg::WORD_LAST)
                        begin
                            word_done   = 1'b1;
                            phase_next  = '0;
                            parity_next = 1'b0;
                            if (pend_valid_reg)
                            begin
                                // Chain the waiting word with no gap
                                pend_valid_next = 1'b0;
                                shift_next      = pend_word_reg;
                                kind_next       = pend_kind_reg;
                            end
                            else
                            begin
                                sending_next = b1553_pkg::ST_IDLE;
                            end
                        end
                        else
                        begin
                            // Shift out a data bit after its second half
                            if (phase_reg >= b1553_pkg::SYNC_END
                                && phase_reg < b1553_pkg::PARITY_START
                                && phase_reg[0])
                            begin
                                parity_next = parity_reg ^ shift_reg[b1553_pkg::WORD_W-1];
                                shift_next  = {shift_reg[b1553_pkg::WORD_W-2:0], 1'b0};
                            end
                            phase_next = phase_reg + 1'b1;
                        end
                    end
                end
                b1553_pkg::OP_LOAD:
                begin
                    if (sending_reg == b1553_pkg::ST_IDLE)
                    begin
                        sending_next    = b1553_pkg::ST_LEAD;
                        phase_next      = '0;
                        shift_next      = data_word;
                        kind_next       = sync_kind;
                        parity_next     = 1'b0;
                        pend_valid_next = 1'b0;
                    end
                    else
                    begin
                        pend_word_next  = data_word;
                        pend_kind_next  = sync_kind;
                        pend_valid_next = 1'b1;
                    end
                end
                b1553_pkg::OP_ABORT:
                begin
                    sending_next    = b1553_pkg::ST_IDLE;
                    phase_next      = '0;
                    parity_next     = 1'b0;
                    pend_valid_next = 1'b0;
                end
                default:
                begin
                    sending_next = sending_reg;
                end
            endcase
        end
    end

    // Result levels
    always_comb
    begin
        if (b1553_pkg::opcode_t'(opcode) == b1553_pkg::OP_TICK)
        begin
            view_state  = sending_reg;
            view_phase  = phase_reg;
            view_msb    = shift_reg[b1553_pkg::WORD_W-1];
            view_parity = parity_reg;
            view_kind   = kind_reg;
        end
        else
        begin
            view_state  = sending_next;
            view_phase  = phase_next;
            view_msb    = shift_next[b1553_pkg::WORD_W-1];
            view_parity = parity_next;
            view_kind   = kind_next;
        end

        if (view_phase < b1553_pkg::SYNC_END)
        begin
            // Sync: three half-bits one way, three the other
            level = (view_phase < b1553_pkg::SYNC_SWAP) ~^ view_kind;
        end
        else if (view_phase < b1553_pkg::PARITY_START)
        begin
            level = view_msb ^ view_phase[0];
        end
        else
        begin
            // Odd parity bit, Manchester coded
            level = ~view_parity ^ (view_phase != b1553_pkg::PARITY_START);
        end

        out_valid_next = out_valid_reg;
        pos_next       = pos_reg;
        neg_next       = neg_reg;
        busy_next      = busy_reg;
        end_next       = end_reg;
        if (in_accept)
        begin
            out_valid_next = 1'b1;
            pos_next       = (view_state == b1553_pkg::ST_WORD) && level;
            neg_next       = (view_state == b1553_pkg::ST_WORD) && !level;
            busy_next      = (view_state != b1553_pkg::ST_IDLE);
            end_next       = word_done;
        end
        else if (out_accept)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sending_reg    <= b1553_pkg::ST_IDLE;
            phase_reg      <= '0;
            shift_reg      <= '0;
            parity_reg     <= 1'b0;
            kind_reg       <= 1'b0;
            pend_word_reg  <= '0;
            pend_kind_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            sending_reg    <= sending_next;
            phase_reg      <= phase_next;
            shift_reg      <= shift_next;
            parity_reg     <= parity_next;
            kind_reg       <= kind_next;
            pend_word_reg  <= pend_word_next;
            pend_kind_reg  <= pend_kind_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        neg_reg  <= neg_next;
        busy_reg <= busy_next;
        end_reg  <= end_next;
    end

    assign out_valid = out_valid_reg;
    assign pos_drive = pos_reg;
    assign neg_drive = neg_reg;
    assign busy_res  = busy_reg;
    assign word_end  = end_reg;

    // Pins stay low whenever nothing is being sent
    a_idle_low: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !busy_reg) |-> (!pos_reg && !neg_reg))
        else $error("pins driven while not busy");

    // A word can only end while it is being sent
    a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && end_reg) |-> busy_reg)
        else $error("word end outside a word");

    // Phase stays inside its frame
    a_word_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (sending_reg == b1553_pkg::ST_WORD) |-> (phase_reg <= b1553_pkg::WORD_LAST))
        else $error("word phase out of range");

    a_lead_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (sending_reg == b1553_pkg::ST_LEAD) |-> (phase_reg <= b1553_pkg::LEAD_LAST))
        else $error("lead-in phase out of range");

    // A chained word only waits behind an active transmission
    a_pend_active: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (sending_reg != b1553_pkg::ST_IDLE))
        else $error("chained word held while idle");

endmodule
